/* sv/acc_pkg.sv */
// ----------------------------------------------------------------------------
// acc_pkg
// shared types and constants of the alignment column consensus core
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

	localparam int SymW   = 8;
	localparam int CntW   = 7;
	localparam int SeenW  = 6;
	localparam int PctW   = 7;
	localparam int Depth  = 256;
	localparam int ProdW  = 13;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	localparam int MaxSequences = 32;

	localparam logic [SymW-1:0] CODE_NONE   = 8'h20;
	localparam logic [SymW-1:0] CODE_WEAK   = 8'h2D;
	localparam logic [SymW-1:0] CODE_STRONG = 8'h2A;

	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_WEAK   = 2'd1;
	localparam logic [1:0] LVL_STRONG = 2'd2;
	localparam logic [1:0] LVL_FULL   = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_WEAK   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_STRONG = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_GAP    = 2'd2;

	typedef struct packed {
		logic [SymW-1:0] residue;
		logic            last_in_column;
	} item_t;

	typedef struct packed {
		logic [SymW-1:0] code;
		logic [1:0]      level;
	} result_t;

	typedef struct packed {
		logic [PctW-1:0] weak_percent;
		logic [PctW-1:0] strong_percent;
		logic [SymW-1:0] gap_symbol;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [SeenW-1:0] best_count;
		logic [SymW-1:0]  best_symbol;
		logic [SeenW-1:0] seen;
	} tally_t;

endpackage

`default_nettype wire

/* sv/acc_count_ram.sv */
// ----------------------------------------------------------------------------
// acc_count_ram
// symbol count memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module acc_count_ram
	import acc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            rd_en,
	input  wire logic [SymW-1:0] rd_addr,
	output logic      [CntW-1:0] rd_data,
	input  wire logic            wr_en,
	input  wire logic [SymW-1:0] wr_addr,
	input  wire logic [CntW-1:0] wr_data
);

	logic [CntW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/acc_tally.sv */
// ----------------------------------------------------------------------------
// acc_tally
// count read-modify-write with forwarding, per-symbol valid bits,
// residue total and running majority
// ----------------------------------------------------------------------------
`default_nettype none

module acc_tally
	import acc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            take,
	input  wire item_t           item,
	input  wire logic [CntW-1:0] rd_data,
	output logic                 wr_en,
	output logic      [SymW-1:0] wr_addr,
	output logic      [CntW-1:0] wr_data,
	output tally_t               tally
);

	logic             v_s1;
	logic [SymW-1:0]  sym_s1;
	logic             last_s1;

	logic [Depth-1:0] valid_q;
	logic [SeenW-1:0] seen_q;
	logic [SeenW-1:0] best_q;
	logic [SymW-1:0]  bsym_q;

	logic             f1_v_q;
	logic [SymW-1:0]  f1_sym_q;
	logic [CntW-1:0]  f1_cnt_q;
	logic             f2_v_q;
	logic [SymW-1:0]  f2_sym_q;
	logic [CntW-1:0]  f2_cnt_q;

	logic [CntW-1:0]  old_cnt;
	logic [CntW-1:0]  new_cnt;
	logic             counted;
	logic             better;
	logic [SeenW-1:0] seen_n;
	logic [SeenW-1:0] best_n;
	logic [SymW-1:0]  bsym_n;

	always_comb begin
		priority if (!valid_q[sym_s1]) begin
			old_cnt = '0;
		end else if (f1_v_q && f1_sym_q == sym_s1) begin
			old_cnt = f1_cnt_q;
		end else if (f2_v_q && f2_sym_q == sym_s1) begin
			old_cnt = f2_cnt_q;
		end else begin
			old_cnt = rd_data;
		end
	end

	assign counted = seen_q < SeenW'(MaxSequences);
	assign new_cnt = old_cnt + CntW'(1);
	assign better  = counted && (new_cnt > {1'b0, best_q});
	assign seen_n  = counted ? seen_q + SeenW'(1) : seen_q;
	assign best_n  = better ? new_cnt[SeenW-1:0] : best_q;
	assign bsym_n  = better ? sym_s1 : bsym_q;

	assign wr_en   = adv && v_s1 && counted;
	assign wr_addr = sym_s1;
	assign wr_data = new_cnt;

	always_comb begin
		tally.valid       = v_s1;
		tally.last        = last_s1;
		tally.best_count  = best_n;
		tally.best_symbol = bsym_n;
		tally.seen        = seen_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sym_s1  <= item.residue;
			last_s1 <= item.last_in_column;
		end
	end

	// column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seen_q  <= '0;
			best_q  <= '0;
			bsym_q  <= '0;
		end else if (adv && v_s1) begin
			if (last_s1) begin
				valid_q <= '0;
				seen_q  <= '0;
				best_q  <= '0;
				bsym_q  <= '0;
			end else begin
				if (counted) begin
					valid_q[sym_s1] <= 1'b1;
				end
				seen_q <= seen_n;
				best_q <= best_n;
				bsym_q <= bsym_n;
			end
		end
	end

	// writes not yet seen by an outstanding read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v_q <= 1'b0;
			f2_v_q <= 1'b0;
		end else if (adv) begin
			f1_v_q <= wr_en;
			f2_v_q <= f1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f1_sym_q <= sym_s1;
			f1_cnt_q <= new_cnt;
			f2_sym_q <= f1_sym_q;
			f2_cnt_q <= f1_cnt_q;
		end
	end

endmodule

`default_nettype wire

/* sv/acc_decide.sv */
// ----------------------------------------------------------------------------
// acc_decide
// share thresholds at column end and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module acc_decide
	import acc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire tally_t  tally,
	input  wire cfg_t    cfg,
	output logic         hold,
	output tally_t       tally_s2,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	logic [ProdW-1:0] best_x100;
	logic [ProdW-1:0] weak_need;
	logic [ProdW-1:0] strong_need;
	logic             weak_ok;
	logic             strong_ok;
	logic             load;
	result_t          res_n;

	assign best_x100   = ProdW'(tally_s2.best_count) * ProdW'(100);
	assign weak_need   = ProdW'(cfg.weak_percent) * ProdW'(tally_s2.seen);
	assign strong_need = ProdW'(cfg.strong_percent) * ProdW'(tally_s2.seen);
	assign weak_ok     = best_x100 >= weak_need;
	assign strong_ok   = best_x100 >= strong_need;

	always_comb begin
		priority if (!weak_ok || tally_s2.best_symbol == cfg.gap_symbol) begin
			res_n.code  = CODE_NONE;
			res_n.level = LVL_NONE;
		end else if (!strong_ok) begin
			res_n.code  = CODE_WEAK;
			res_n.level = LVL_WEAK;
		end else if (tally_s2.best_count == tally_s2.seen) begin
			res_n.code  = tally_s2.best_symbol;
			res_n.level = LVL_FULL;
		end else begin
			res_n.code  = CODE_STRONG;
			res_n.level = LVL_STRONG;
		end
	end

	assign hold = tally_s2.valid && tally_s2.last && result_valid && result_stall;
	assign load = tally_s2.valid && tally_s2.last && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_s2 <= '0;
		end else if (adv) begin
			tally_s2 <= tally;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= res_n;
		end
	end

endmodule

`default_nettype wire

/* sv/alignment_column_consensus_core.sv */
// a column end passes the stage 1 register, tally_s2 and result in turn; one residue
//   per cycle unless stalled, set by the single count memory read-modify-write
//   with two-deep write forwarding; a waiting result stalls the next column end
// reset: configuration returns to 60 / 80 / '-', per-symbol valid flops clear at once,
//   so counts read as zero without a clearing pass; the block takes requests right away
// ----------------------------------------------------------------------------
// alignment_column_consensus_core
// majority-vote consensus of one alignment column, one residue per request
// ----------------------------------------------------------------------------
`default_nettype none

module alignment_column_consensus_core
	import acc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire item_t               item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output result_t                  result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t            cfg_q;
	logic            adv;
	logic            hold;
	logic            take;
	logic [CntW-1:0] rd_data;
	logic            wr_en;
	logic [SymW-1:0] wr_addr;
	logic [CntW-1:0] wr_data;
	tally_t          tally;
	tally_t          tally_s2;

	assign adv        = !hold;
	assign item_stall = hold;
	assign take       = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weak_percent   <= PctW'(60);
			cfg_q.strong_percent <= PctW'(80);
			cfg_q.gap_symbol     <= SymW'(45);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WEAK:   cfg_q.weak_percent   <= cfg_data[PctW-1:0];
				CFG_STRONG: cfg_q.strong_percent <= cfg_data[PctW-1:0];
				CFG_GAP:    cfg_q.gap_symbol     <= cfg_data[SymW-1:0];
				default: ;
			endcase
		end
	end

	acc_count_ram u_ram (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (item.residue),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	acc_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (take),
		.item    (item),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.tally   (tally)
	);

	acc_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tally        (tally),
		.cfg          (cfg_q),
		.hold         (hold),
		.tally_s2     (tally_s2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_on_blocked_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && tally_s2.valid && tally_s2.last))
		else $error("request stalled without a blocked result");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tally.valid |-> (tally.seen <= SeenW'(MaxSequences)))
		else $error("residue total above sequence limit");

	a_best_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		tally_s2.valid |-> (tally_s2.best_count <= tally_s2.seen))
		else $error("majority count above residue total");

	a_result_from_column_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(tally_s2.valid && tally_s2.last))
		else $error("result without a column end");
`endif

endmodule

`default_nettype wire
